// ----- sv/skh_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// skh_pkg
// Shared types, constants and functions of the string key hash block.
// ----------------------------------------------------------------------------
package skh_pkg;

   localparam logic [31:0] CrcPoly    = 32'hEDB8_8320;
   localparam logic [31:0] KnuthMult  = 32'd2654435761;
   localparam logic [19:0] BucketMod  = 20'd1000000;

   // 1000000 = 64 * 15625; quotient estimate of (m >> 6) / 15625
   localparam int          ModShift   = 6;
   localparam int          RecipShift = 40;
   localparam logic [26:0] RecipMult  = 27'd70368744;   // floor(2^40 / 15625)

   // one stage's worth of data moving down the hash pipeline
   typedef struct packed {
      logic        valid;
      logic [31:0] data;
   } hand_type;

   function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {24'd0, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
      end
      return c;
   endfunction

   // first half of the 32-bit integer mix
   function automatic logic [31:0] mix_a(input logic [31:0] x_i);
      logic [31:0] x;
      x = x_i + (x_i << 12);
      x = x ^ (x >> 22);
      x = x + (x << 4);
      x = x ^ (x >> 9);
      return x;
   endfunction

   // second half of the 32-bit integer mix
   function automatic logic [31:0] mix_b(input logic [31:0] x_i);
      logic [31:0] x;
      x = x_i + (x_i << 10);
      x = x ^ (x >> 2);
      x = x + (x << 7);
      x = x ^ (x >> 12);
      return x;
   endfunction

endpackage
`default_nettype wire

// ----- sv/string_key_hash.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// string_key_hash
// Bucket hash of byte-string keys: CRC-32 per byte, integer mix, Knuth
// multiply and reduction modulo 1000000 on the last byte of each key.
// ----------------------------------------------------------------------------
//  channel  direction  handshake            payload
//  req      in         req_valid/req_stall  req_key_byte[7:0], req_last_byte
//  rsp      out        rsp_valid/rsp_stall  rsp_hash_value[19:0]
//
//  One key byte per clock is taken while req is not stalled; bytes of the
//  next key follow the last byte of a key without a gap.
//  Once its last byte is accepted, a hash passes through the pipeline:
//  input register, CRC stage, two mix stages, multiply stage,
//  quotient stage and result register.
//  Synchronous reset clears the CRC and all valid bits.
//  Stalls on rsp back up stage by stage; req stalls only when a last byte
//  finds the hash pipeline full.
// ----------------------------------------------------------------------------
module string_key_hash (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output      logic        req_stall,
   input  wire logic [7:0]  req_key_byte,
   input  wire logic        req_last_byte,
   output      logic        rsp_valid,
   input  wire logic        rsp_stall,
   output      logic [19:0] rsp_hash_value
);

   skh_pkg::hand_type fin;
   skh_pkg::hand_type mixed;
   logic              fin_ready;
   logic              mixed_ready;

   skh_crc u_crc (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_key_byte  (req_key_byte),
      .req_last_byte (req_last_byte),
      .fin           (fin),
      .fin_ready     (fin_ready)
   );

   skh_mix u_mix (
      .clock      (clock),
      .reset      (reset),
      .up         (fin),
      .up_ready   (fin_ready),
      .down       (mixed),
      .down_ready (mixed_ready)
   );

   skh_mod u_mod (
      .clock          (clock),
      .reset          (reset),
      .up             (mixed),
      .up_ready       (mixed_ready),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_hash_value (rsp_hash_value)
   );

endmodule
`default_nettype wire

// ----- sv/skh_crc.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// skh_crc
// Input register and byte-wise CRC-32; hands the final CRC of a key onward.
// ----------------------------------------------------------------------------
module skh_crc (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output      logic              req_stall,
   input  wire logic [7:0]        req_key_byte,
   input  wire logic              req_last_byte,
   output      skh_pkg::hand_type fin,
   input  wire logic              fin_ready
);

   logic        in_valid_ff;
   logic [7:0]  byte_ff;
   logic        last_ff;
   logic [31:0] crc_ff;
   logic [31:0] crc_in;
   logic        fin_valid_ff;
   logic [31:0] fin_crc_ff;
   logic        fin_load;
   logic        in_adv;
   logic        accept;
   logic [31:0] crc_upd;

   assign crc_upd   = skh_pkg::crc_byte(crc_ff, byte_ff);
   assign fin_load  = !fin_valid_ff || fin_ready;
   // bytes without the mark never wait on the hash pipeline
   assign in_adv    = in_valid_ff && (!last_ff || fin_load);
   assign req_stall = in_valid_ff && !in_adv;
   assign accept    = req_valid && !req_stall;
   assign crc_in    = last_ff ? 32'd0 : crc_upd;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         fin_valid_ff <= 1'b0;
         crc_ff       <= 32'd0;
      end else begin
         if (accept) begin
            in_valid_ff <= 1'b1;
         end else if (in_adv) begin
            in_valid_ff <= 1'b0;
         end
         if (in_adv) begin
            crc_ff <= crc_in;
         end
         if (fin_load) begin
            fin_valid_ff <= in_adv && last_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         byte_ff <= req_key_byte;
         last_ff <= req_last_byte;
      end
      if (fin_load) begin
         fin_crc_ff <= crc_upd;
      end
   end

   assign fin.valid = fin_valid_ff;
   assign fin.data  = fin_crc_ff;

`ifndef SYNTHESIS
   a_crc_clear: assert property (@(posedge clock) disable iff (reset)
      in_adv && last_ff |=> crc_ff == 32'd0)
      else $error("crc not cleared after last byte");
   a_no_stall_mid_key: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !last_ff |-> !req_stall)
      else $error("stall on a byte that is not last");
   a_fin_hold: assert property (@(posedge clock) disable iff (reset)
      fin_valid_ff && !fin_ready |=> fin_valid_ff && $stable(fin_crc_ff))
      else $error("final crc lost while held");
`endif

endmodule
`default_nettype wire

// ----- sv/skh_mix.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// skh_mix
// Integer mix in two stages, then shift and Knuth multiply in a third.
// ----------------------------------------------------------------------------
module skh_mix (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire skh_pkg::hand_type up,
   output      logic              up_ready,
   output      skh_pkg::hand_type down,
   input  wire logic              down_ready
);

   logic        s1_valid_ff, s2_valid_ff, s3_valid_ff;
   logic [31:0] s1_ff, s2_ff, s3_ff;
   logic        s1_load, s2_load, s3_load;
   logic [31:0] prod;

   assign s3_load  = !s3_valid_ff || down_ready;
   assign s2_load  = !s2_valid_ff || s3_load;
   assign s1_load  = !s1_valid_ff || s2_load;
   assign up_ready = s1_load;

   assign prod = {3'd0, s2_ff[31:3]} * skh_pkg::KnuthMult;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         if (s1_load) s1_valid_ff <= up.valid;
         if (s2_load) s2_valid_ff <= s1_valid_ff;
         if (s3_load) s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_load) s1_ff <= skh_pkg::mix_a(up.data);
      if (s2_load) s2_ff <= skh_pkg::mix_b(s1_ff);
      if (s3_load) s3_ff <= prod;
   end

   assign down.valid = s3_valid_ff;
   assign down.data  = s3_ff;

endmodule
`default_nettype wire

// ----- sv/skh_mod.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// skh_mod
// Reduction modulo 1000000: reciprocal quotient estimate, then one
// multiply-subtract with a single correction into the result register.
// ----------------------------------------------------------------------------
module skh_mod (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire skh_pkg::hand_type up,
   output      logic              up_ready,
   output      logic              rsp_valid,
   input  wire logic              rsp_stall,
   output      logic [19:0]       rsp_hash_value
);

   logic        q_valid_ff;
   logic [12:0] q_ff;
   logic [20:0] m_ff;
   logic        rsp_valid_ff;
   logic [19:0] hash_ff;
   logic [19:0] hash_in;
   logic        q_load, rsp_load;
   logic [52:0] recip_prod;
   logic [12:0] q_est;
   logic [20:0] qm_prod;
   logic [20:0] rem_raw;

   assign rsp_load = !rsp_valid_ff || !rsp_stall;
   assign q_load   = !q_valid_ff || rsp_load;
   assign up_ready = q_load;

   // estimate is the true quotient or one below it
   assign recip_prod = {1'b0, up.data[31:skh_pkg::ModShift]} * {26'd0, skh_pkg::RecipMult};
   assign q_est      = recip_prod[skh_pkg::RecipShift +: 13];

   // remainder is below 2 * 1000000, so 21 bits carry it exactly
   assign qm_prod = 21'({8'd0, q_ff} * {1'b0, skh_pkg::BucketMod});
   assign rem_raw = m_ff - qm_prod;
   assign hash_in = (rem_raw >= {1'b0, skh_pkg::BucketMod})
                    ? 20'(rem_raw - {1'b0, skh_pkg::BucketMod}) : rem_raw[19:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         q_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (q_load)   q_valid_ff   <= up.valid;
         if (rsp_load) rsp_valid_ff <= q_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (q_load) begin
         q_ff <= q_est;
         m_ff <= up.data[20:0];
      end
      if (rsp_load) hash_ff <= hash_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hash_value = hash_ff;

`ifndef SYNTHESIS
   a_rem_range: assert property (@(posedge clock) disable iff (reset)
      q_valid_ff |-> rem_raw < 21'd2000000)
      else $error("quotient estimate out of range");
   a_hash_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> hash_ff < skh_pkg::BucketMod)
      else $error("hash value not reduced");
   a_q_hold: assert property (@(posedge clock) disable iff (reset)
      q_valid_ff && !rsp_load |=> q_valid_ff && $stable(q_ff) && $stable(m_ff))
      else $error("quotient stage lost while held");
`endif

endmodule
`default_nettype wire

// ----- test/string_key_hash_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// string_key_hash_checker
// Watches both channels of string_key_hash. It keeps its own CRC of the key
// in progress, queues the bucket hash due at each last byte, and compares
// every hash item that leaves the block with the oldest one queued.
// ----------------------------------------------------------------------------
module string_key_hash_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic        req_stall,
   input  wire logic [7:0]  req_key_byte,
   input  wire logic        req_last_byte,
   input  wire logic        rsp_valid,
   input  wire logic        rsp_stall,
   input  wire logic [19:0] rsp_hash_value,
   output int               mismatch_count,
   output int               hashes_pending
);

   localparam logic [31:0] ReflectedPoly = 32'hEDB8_8320;
   localparam logic [31:0] GoldenMult    = 32'd2654435761;
   localparam logic [31:0] BucketCount   = 32'd1000000;

   logic [31:0] key_crc = '0;
   logic [19:0] hash_queue[$];

   initial begin
      mismatch_count = 0;
      hashes_pending = 0;
   end

   // reflected CRC-32, one byte, LSB first
   function automatic logic [31:0] crc_after_byte(input logic [31:0] crc,
                                                  input logic [7:0]  b);
      logic [31:0] r;
      r = crc ^ {24'h0, b};
      repeat (8) r = r[0] ? ((r >> 1) ^ ReflectedPoly) : (r >> 1);
      return r;
   endfunction

   // integer mix, Knuth multiply, reduce into the bucket range
   function automatic logic [19:0] bucket_of(input logic [31:0] crc);
      logic [31:0] x;
      logic [31:0] m;
      x = crc + (crc << 12);
      x = x ^ (x >> 22);
      x = x + (x << 4);
      x = x ^ (x >> 9);
      x = x + (x << 10);
      x = x ^ (x >> 2);
      x = x + (x << 7);
      x = x ^ (x >> 12);
      m = (x >> 3) * GoldenMult;
      m = m % BucketCount;
      return m[19:0];
   endfunction

   always @(posedge clock) begin : watch
      logic [31:0] next_crc;
      logic [19:0] want;
      if (reset) begin
         key_crc <= '0;
         hash_queue.delete();
         hashes_pending <= 0;
      end else begin
         if (req_valid && !req_stall) begin
            next_crc = crc_after_byte(key_crc, req_key_byte);
            if (req_last_byte) begin
               hash_queue.push_back(bucket_of(next_crc));
               key_crc <= '0;
            end else begin
               key_crc <= next_crc;
            end
         end
         if (rsp_valid && !rsp_stall) begin
            if (hash_queue.size() == 0) begin
               $error("unexpected item: hash_value expected none, actual %0d",
                      rsp_hash_value);
               mismatch_count <= mismatch_count + 1;
            end else begin
               want = hash_queue.pop_front();
               if (rsp_hash_value !== want) begin
                  $error("hash_value mismatch: expected %0d, actual %0d",
                         want, rsp_hash_value);
                  mismatch_count <= mismatch_count + 1;
               end
            end
         end
         hashes_pending <= hash_queue.size();
      end
   end

endmodule

// ----- test/string_key_hash_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// string_key_hash_tb
// Feeds keys byte by byte into string_key_hash: a few hand-picked keys, then
// random keys of mixed length under three idle patterns on both channels.
// The checker beside the block predicts and compares each bucket hash.
// ----------------------------------------------------------------------------
module string_key_hash_tb;

   localparam int CycleLimit = 400000;
   localparam int TailCycles = 12;

   logic        clock         = 1'b0;
   logic        reset         = 1'b1;
   logic        req_valid     = 1'b0;
   logic [7:0]  req_key_byte  = '0;
   logic        req_last_byte = 1'b0;
   logic        rsp_stall     = 1'b0;
   logic        req_stall;
   logic        rsp_valid;
   logic [19:0] rsp_hash_value;

   int mismatch_count;
   int hashes_pending;
   int tx_idle_pct = 0;
   int rx_idle_pct = 0;
   int bytes_sent  = 0;
   int cycle_count = 0;

   string_key_hash u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_key_byte   (req_key_byte),
      .req_last_byte  (req_last_byte),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_hash_value (rsp_hash_value)
   );

   string_key_hash_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_key_byte   (req_key_byte),
      .req_last_byte  (req_last_byte),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_hash_value (rsp_hash_value),
      .mismatch_count (mismatch_count),
      .hashes_pending (hashes_pending)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < rx_idle_pct);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CycleLimit) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // one key byte; returns at the edge where it was taken
   task automatic put_byte(input logic [7:0] b, input logic last);
      if ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < tx_idle_pct);
      end
      req_valid     <= 1'b1;
      req_key_byte  <= b;
      req_last_byte <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      bytes_sent++;
   endtask

   task automatic put_random_key(input int len);
      for (int i = 0; i < len; i++) put_byte(8'($urandom), i == len - 1);
   endtask

   // hold off until every hash owed has come out
   task automatic drain;
      req_valid <= 1'b0;
      @(posedge clock);
      while (hashes_pending != 0) @(posedge clock);
   endtask

   task automatic run_phase(input int tx_pct, input int rx_pct, input int n_bytes);
      int target;
      int len;
      tx_idle_pct = tx_pct;
      rx_idle_pct = rx_pct;
      target      = bytes_sent + n_bytes;
      while (bytes_sent < target) begin
         // mostly short keys, now and then a long one
         len = ($urandom_range(9) == 0) ? $urandom_range(64, 24) : $urandom_range(10, 1);
         put_random_key(len);
      end
      drain();
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // one-byte keys at both byte extremes
      put_byte(8'h00, 1'b1);
      put_byte(8'hFF, 1'b1);
      // unmarked bytes only feed the CRC
      put_byte(8'h00, 1'b0);
      put_byte(8'h00, 1'b1);
      put_byte(8'hFF, 1'b0);
      put_byte(8'hFF, 1'b0);
      put_byte(8'hFF, 1'b1);
      put_byte(8'h61, 1'b0);
      put_byte(8'h62, 1'b0);
      put_byte(8'h63, 1'b1);
      put_byte(8'h55, 1'b0);
      put_byte(8'hAA, 1'b1);
      // walking one across the byte
      for (int i = 0; i < 8; i++) put_byte(8'(1 << i), i == 7);
      drain();

      run_phase(28, 61, 145);
      run_phase(61, 28, 145);
      run_phase(0, 0, 145);

      repeat (TailCycles) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
